// File: src/jkv_pkg.sv
// Shared types, constants and helpers for the JSON key/value scanner.
// Used by jkv_window, jkv_value and json_key_value_scanner; no dependencies.
package jkv_pkg;

	localparam int MAX_FIELD_CHARS = 16;
	localparam int WIN_LEN = MAX_FIELD_CHARS + 3;
	localparam int LEN_W = 5;
	localparam int VALUE_W = 16;
	localparam int ACC_W = 20;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_F = 8'h66;
	localparam logic [ACC_W-1:0] VALUE_MAX = ACC_W'(65535);

	// Configuration register indexes.
	localparam logic [1:0] REG_CHARS_LOW = 2'd0;
	localparam logic [1:0] REG_CHARS_HIGH = 2'd1;
	localparam logic [1:0] REG_FIELD_LEN = 2'd2;
	localparam logic [1:0] REG_VALUE_MODE = 2'd3;

	// Value modes.
	localparam logic MODE_UINT16 = 1'b0;
	localparam logic MODE_BOOL = 1'b1;

	// Input item kinds.
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_END = 1'b1;

	typedef struct packed {
		logic kind;
		logic [7:0] text_byte;
	} item_t;

	typedef struct packed {
		logic valid;
		logic found;
		logic [VALUE_W-1:0] parsed_value;
	} result_t;

	// Control from the phase logic to the key window.
	typedef struct packed {
		logic shift;
		logic clear;
	} win_ctl_t;

	// Character of "true" or "false" at a given position.
	function automatic logic [7:0] word_char(input logic is_true, input logic [2:0] idx);
		logic [7:0] c;
		c = 8'h00;
		if (is_true) begin
			case (idx)
				3'd0: c = 8'h74;
				3'd1: c = 8'h72;
				3'd2: c = 8'h75;
				3'd3: c = 8'h65;
				default: c = 8'h00;
			endcase
		end else begin
			case (idx)
				3'd0: c = 8'h66;
				3'd1: c = 8'h61;
				3'd2: c = 8'h6c;
				3'd3: c = 8'h73;
				3'd4: c = 8'h65;
				default: c = 8'h00;
			endcase
		end
		return c;
	endfunction

endpackage

// File: src/json_key_value_scanner.sv
// Top level of the JSON key/value scanner: streaming ports, configuration
// registers, input and result registers. Depends on jkv_pkg, jkv_window, jkv_value.

// The scanner takes one body byte per cycle and gives one result per body.
// An item passes an input register, then the window compare and parse step,
// and the result lands in an output register. Input stalls while a result
// waits unaccepted in the output register and an item sits in the input
// register; otherwise s_tready stays high and the sustained rate is one byte
// per cycle. The key is matched against a 19-byte window of the most recent
// bytes, and configuration is read live.
module json_key_value_scanner import jkv_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,   // [7:0] text_byte
	input  logic                s_tuser,   // [0] kind
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [VALUE_W-1:0]  m_tdata,   // [15:0] parsed_value
	output logic                m_tuser,   // [0] found
	input  logic                wr_en,
	input  logic [1:0]          wr_index,
	input  logic [63:0]         wr_data
);

	logic [63:0] chars_low_q;
	logic [63:0] chars_high_q;
	logic [LEN_W-1:0] field_len_q;
	logic value_mode_q;

	logic s1_valid_s1;
	item_t s1_item_s1;
	logic out_valid_q;
	logic out_found_q;
	logic [VALUE_W-1:0] out_value_q;

	logic advance;
	logic step;
	logic key_hit;
	win_ctl_t win_ctl;
	result_t res;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_low_q <= '0;
			chars_high_q <= '0;
			field_len_q <= LEN_W'(1);
			value_mode_q <= MODE_UINT16;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_CHARS_LOW: chars_low_q <= wr_data;
				REG_CHARS_HIGH: chars_high_q <= wr_data;
				REG_FIELD_LEN: field_len_q <= wr_data[LEN_W-1:0];
				REG_VALUE_MODE: value_mode_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	// The input register moves on whenever the result register can take a result.
	assign advance = !out_valid_q || m_tready;
	assign step = s1_valid_s1 && advance;
	assign s_tready = !s1_valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			s1_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			s1_item_s1.kind <= s_tuser;
			s1_item_s1.text_byte <= s_tdata;
		end
	end

	jkv_window u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (win_ctl),
		.text_byte    (s1_item_s1.text_byte),
		.name_chars   ({chars_high_q, chars_low_q}),
		.field_length (field_len_q),
		.key_hit      (key_hit)
	);

	jkv_value u_value (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.item       (s1_item_s1),
		.key_hit    (key_hit),
		.value_mode (value_mode_q),
		.win_ctl    (win_ctl),
		.res        (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid) begin
			out_found_q <= res.found;
			out_value_q <= res.parsed_value;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = out_found_q;
	assign m_tdata = out_value_q;

`ifndef SYNTHESIS
	// A failed request always reports a zero value.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("failed result carries a nonzero value");

	// A new result only appears after an item was taken from the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s1_valid_s1))
		else $error("result appeared with no item in the input register");

	// A waiting item in the input register is held while the output is blocked.
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 && !advance |=> s1_valid_s1 && $stable(s1_item_s1))
		else $error("input register changed while stalled");

	// A successful boolean result is 0 or 1.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) && m_tuser && value_mode_q == MODE_BOOL |-> m_tdata <= VALUE_W'(1))
		else $error("boolean result out of range");
`endif

endmodule

// File: src/jkv_window.sv
// Sliding window of recent body bytes and the key pattern compare.
// Depends on jkv_pkg.
module jkv_window import jkv_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  win_ctl_t                     ctl,
	input  logic [7:0]                   text_byte,
	input  logic [MAX_FIELD_CHARS*8-1:0] name_chars,
	input  logic [LEN_W-1:0]             field_length,
	output logic                         key_hit
);

	logic [7:0] win_q [WIN_LEN];
	logic [7:0] next_win [WIN_LEN];

	// Window as it stands once the current byte has shifted in.
	always_comb begin
		for (int j = 0; j < WIN_LEN; j++) begin
			next_win[j] = (j == WIN_LEN - 1) ? text_byte : win_q[(j + 1) % WIN_LEN];
		end
	end

	// Compare the tail of the window with quote, name, quote, colon.
	always_comb begin
		int lenv;
		logic [7:0] want;
		lenv = int'(field_length);
		key_hit = (lenv <= MAX_FIELD_CHARS);
		for (int j = 0; j < WIN_LEN; j++) begin
			want = 8'h00;
			if (lenv <= MAX_FIELD_CHARS && j >= WIN_LEN - 3 - lenv) begin
				if (j == WIN_LEN - 3 - lenv || j == WIN_LEN - 2) begin
					want = CH_QUOTE;
				end else if (j == WIN_LEN - 1) begin
					want = CH_COLON;
				end else begin
					want = name_chars[(j - (WIN_LEN - 2) + lenv) * 8 +: 8];
				end
				if (next_win[j] != want) begin
					key_hit = 1'b0;
				end
			end
		end
	end

	// Shift while searching; clear at the end of a body.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < WIN_LEN; j++) begin
				win_q[j] <= 8'h00;
			end
		end else if (ctl.clear) begin
			for (int j = 0; j < WIN_LEN; j++) begin
				win_q[j] <= 8'h00;
			end
		end else if (ctl.shift) begin
			win_q <= next_win;
		end
	end

endmodule

// File: src/jkv_value.sv
// Scan phase state machine: blank skipping, decimal and boolean parsing, results.
// Depends on jkv_pkg.
module jkv_value import jkv_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  item_t    item,
	input  logic     key_hit,
	input  logic     value_mode,
	output win_ctl_t win_ctl,
	output result_t  res
);

	typedef enum logic [4:0] {
		PH_SEARCH = 5'b00001,
		PH_BLANKS = 5'b00010,
		PH_DIGITS = 5'b00100,
		PH_WORD   = 5'b01000,
		PH_DONE   = 5'b10000
	} phase_t;

	phase_t phase_q, phase_d;
	logic [VALUE_W-1:0] acc_q, acc_d;
	logic [2:0] idx_q, idx_d;
	logic expect_true_q, expect_true_d;

	logic terminator;
	logic is_digit;
	logic [3:0] digit;
	logic [ACC_W-1:0] next_acc;
	logic [2:0] wlen;
	logic [2:0] idx_inc;

	assign terminator = (item.kind == KIND_END) || (item.text_byte == 8'h00);
	assign is_digit = (item.text_byte >= CH_ZERO) && (item.text_byte <= CH_NINE);
	assign digit = 4'(item.text_byte - CH_ZERO);
	assign next_acc = (ACC_W'(acc_q) << 3) + (ACC_W'(acc_q) << 1) + ACC_W'(digit);
	assign wlen = expect_true_q ? 3'd4 : 3'd5;
	assign idx_inc = idx_q + 3'd1;

	assign win_ctl.shift = step && !terminator && (phase_q == PH_SEARCH);
	assign win_ctl.clear = step && (item.kind == KIND_END);

	// Next state and result for the item in the input register.
	always_comb begin
		phase_d = phase_q;
		acc_d = acc_q;
		idx_d = idx_q;
		expect_true_d = expect_true_q;
		res = '0;
		if (terminator) begin
			if (phase_q != PH_DONE) begin
				res.valid = 1'b1;
				res.found = (phase_q == PH_DIGITS);
				res.parsed_value = (phase_q == PH_DIGITS) ? acc_q : '0;
			end
			if (item.kind == KIND_END) begin
				phase_d = PH_SEARCH;
				acc_d = '0;
				idx_d = '0;
				expect_true_d = 1'b0;
			end else begin
				phase_d = PH_DONE;
			end
		end else begin
			unique case (phase_q)
				PH_SEARCH: begin
					if (key_hit) begin
						phase_d = PH_BLANKS;
					end
				end
				PH_BLANKS: begin
					if (item.text_byte == CH_SPACE || item.text_byte == CH_TAB) begin
						phase_d = PH_BLANKS;
					end else if (value_mode == MODE_UINT16) begin
						if (is_digit) begin
							acc_d = VALUE_W'(digit);
							phase_d = PH_DIGITS;
						end else begin
							res.valid = 1'b1;
							phase_d = PH_DONE;
						end
					end else if (item.text_byte == CH_T || item.text_byte == CH_F) begin
						expect_true_d = (item.text_byte == CH_T);
						idx_d = 3'd1;
						phase_d = PH_WORD;
					end else begin
						res.valid = 1'b1;
						phase_d = PH_DONE;
					end
				end
				PH_DIGITS: begin
					if (!is_digit) begin
						res.valid = 1'b1;
						res.found = 1'b1;
						res.parsed_value = acc_q;
						phase_d = PH_DONE;
					end else if (next_acc > VALUE_MAX) begin
						res.valid = 1'b1;
						phase_d = PH_DONE;
					end else begin
						acc_d = next_acc[VALUE_W-1:0];
					end
				end
				PH_WORD: begin
					if (idx_q >= wlen || item.text_byte != word_char(expect_true_q, idx_q)) begin
						res.valid = 1'b1;
						phase_d = PH_DONE;
					end else if (idx_inc == wlen) begin
						res.valid = 1'b1;
						res.found = 1'b1;
						res.parsed_value = VALUE_W'(expect_true_q);
						idx_d = idx_inc;
						phase_d = PH_DONE;
					end else begin
						idx_d = idx_inc;
					end
				end
				PH_DONE: begin
					phase_d = PH_DONE;
				end
				default: begin
					phase_d = PH_SEARCH;
				end
			endcase
		end
	end

	// Phase and parse state advance only when an item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			acc_q <= '0;
			idx_q <= '0;
			expect_true_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			acc_q <= acc_d;
			idx_q <= idx_d;
			expect_true_q <= expect_true_d;
		end
	end

endmodule
